@@ rtl/epsm_pkg.sv @@
// shared types and constants for the encoder period speed meter
package epsm_pkg;

  localparam int unsigned SpanWidth  = 16;
  localparam int unsigned LimitWidth = 7;
  localparam int unsigned NumWidth   = 24;
  localparam int unsigned ValWidth   = 24;
  localparam int unsigned TotalWidth = 16;

  localparam logic [ValWidth-1:0]   Full24        = 24'hFFFFFF;
  localparam logic [6:0]            PresetFactor  = 7'd100;
  localparam logic [ValWidth-1:0]   PeriodReset   = 24'd9999;
  localparam logic [SpanWidth-1:0]  SpanReset     = 16'd65535;
  localparam logic [LimitWidth-1:0] LimitReset    = 7'd100;
  localparam logic [NumWidth-1:0]   NumReset      = 24'd937500;
  localparam logic [TotalWidth-1:0] PulseTallyMax = 16'hFFFF;

  localparam logic [1:0] RegCounterSpan    = 2'd0;
  localparam logic [1:0] RegStaleLimit     = 2'd1;
  localparam logic [1:0] RegSpeedNumerator = 2'd2;

  typedef struct packed {
    logic [SpanWidth-1:0]  counter_span;
    logic [LimitWidth-1:0] stale_limit;
    logic [NumWidth-1:0]   speed_numerator;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic tally;
    logic product;
    logic subtract;
    logic ring;
    logic div_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic pulse_event;
    logic div_busy;
  } sts_t;

endpackage

@@ rtl/epsm_divider.sv @@
// restoring bit-serial divider, one quotient bit per cycle
module epsm_divider
  import epsm_pkg::*;
#(
  parameter int unsigned W = 27
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         busy_o,
  output logic [W-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  quo_q;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic [W:0]    trial;
  logic          ge;

  assign trial = {rem_q, quo_q[W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    if (ge) begin
      rem_d = W'(trial - {1'b0, dvs_q});
    end else begin
      rem_d = trial[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/epsm_datapath.sv @@
// period, overflow, ring and speed datapath
module epsm_datapath
  import epsm_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic                  action_i,
  input  logic                  overflow_flag_i,
  input  logic                  pulse_flag_i,
  input  logic [SpanWidth-1:0]  latched_count_i,
  output logic [ValWidth-1:0]   period_ticks_o,
  output logic [ValWidth-1:0]   speed_rpm_o,
  output logic [ValWidth-1:0]   average_speed_rpm_o,
  output logic                  average_invalid_o,
  output logic [TotalWidth-1:0] pulse_total_o
);

  localparam int unsigned PW = $clog2(RING_DEPTH);
  localparam int unsigned TW = ValWidth + $clog2(RING_DEPTH);

  // captured transaction
  logic                 action_q, ovf_q, pulse_q;
  logic [SpanWidth-1:0] lat_q;

  // measurement state
  logic [ValWidth-1:0]   latest_q;
  logic [LimitWidth-1:0] tally_q;
  logic [RING_DEPTH-1:0] valid_q;
  logic [PW-1:0]         pos_q;
  logic [TW-1:0]         total_q;
  logic [TotalWidth-1:0] pulse_tally_q;

  logic [ValWidth-1:0]   ring_mem [RING_DEPTH];
  logic [ValWidth-1:0]   rd_q;
  logic [ValWidth-1:0]   prod_q;
  logic [ValWidth-1:0]   period_q;
  logic [TotalWidth-1:0] total_out_q;

  logic [LimitWidth:0]   tally_inc;
  logic                  stale;
  logic [ValWidth-1:0]   preset;
  logic [ValWidth-1:0]   old_entry;
  logic [TotalWidth-1:0] pulse_sat;
  logic [PW-1:0]         pos_next;

  logic          busy_a, busy_b;
  logic [TW-1:0] quo_a, quo_b;

  assign tally_inc = ovf_q ? ({1'b0, tally_q} + (LimitWidth+1)'(1)) : {1'b0, tally_q};
  assign stale     = tally_inc > {1'b0, cfg_i.stale_limit};
  assign preset    = ValWidth'(cfg_i.counter_span) * ValWidth'(PresetFactor);
  assign old_entry = valid_q[pos_q] ? rd_q : '0;
  assign pulse_sat = (pulse_tally_q == PulseTallyMax) ? pulse_tally_q
                                                      : pulse_tally_q + TotalWidth'(1);
  assign pos_next  = (pos_q == PW'(RING_DEPTH - 1)) ? '0 : pos_q + PW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= action_i;
      ovf_q    <= overflow_flag_i;
      pulse_q  <= pulse_flag_i;
      lat_q    <= latched_count_i;
    end
    if (cmd_i.tally) begin
      total_out_q <= pulse_tally_q;
    end
    if (cmd_i.product) begin
      prod_q <= ValWidth'(cfg_i.counter_span)
              * ValWidth'({1'b0, tally_q} + (LimitWidth+1)'(1));
    end
    if (cmd_i.subtract) begin
      period_q <= (prod_q > ValWidth'(lat_q)) ? prod_q - ValWidth'(lat_q) : '0;
    end
    if (cmd_i.ring) begin
      ring_mem[pos_q] <= period_q;
      total_out_q     <= pulse_sat;
    end
    rd_q <= ring_mem[pos_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latest_q      <= PeriodReset;
      tally_q       <= '0;
      valid_q       <= '0;
      pos_q         <= '0;
      total_q       <= '0;
      pulse_tally_q <= '0;
    end else if (cmd_i.tally) begin
      if (action_q) begin
        pulse_tally_q <= '0;
      end else begin
        latest_q <= preset;
        if (stale) begin
          tally_q <= '0;
          valid_q <= '0;
          total_q <= '0;
        end else begin
          tally_q <= tally_inc[LimitWidth-1:0];
        end
      end
    end else if (cmd_i.ring) begin
      latest_q       <= period_q;
      valid_q[pos_q] <= 1'b1;
      total_q        <= total_q - TW'(old_entry) + TW'(period_q);
      pos_q          <= pos_next;
      pulse_tally_q  <= pulse_sat;
      tally_q        <= '0;
    end
  end

  epsm_divider #(
    .W(TW)
  ) u_div_speed (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (TW'(cfg_i.speed_numerator)),
    .divisor_i  (TW'(latest_q)),
    .busy_o     (busy_a),
    .quotient_o (quo_a)
  );

  epsm_divider #(
    .W(TW)
  ) u_div_average (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (TW'(TW'(cfg_i.speed_numerator) * TW'(RING_DEPTH))),
    .divisor_i  (total_q),
    .busy_o     (busy_b),
    .quotient_o (quo_b)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      period_ticks_o <= latest_q;
      if ((latest_q == '0) || (quo_a > TW'(Full24))) begin
        speed_rpm_o <= Full24;
      end else begin
        speed_rpm_o <= quo_a[ValWidth-1:0];
      end
      if ((total_q == '0) || (quo_b > TW'(Full24))) begin
        average_speed_rpm_o <= Full24;
      end else begin
        average_speed_rpm_o <= quo_b[ValWidth-1:0];
      end
      average_invalid_o <= (total_q == '0);
      pulse_total_o     <= total_out_q;
    end
  end

  assign sts_o.pulse_event = !action_q && pulse_q;
  assign sts_o.div_busy    = busy_a || busy_b;

endmodule

@@ rtl/epsm_controller.sv @@
// sequencing state machine and output handshake
module epsm_controller
  import epsm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [6:0] {
    StIdle     = 7'b0000001,
    StTally    = 7'b0000010,
    StProduct  = 7'b0000100,
    StSubtract = 7'b0001000,
    StRing     = 7'b0010000,
    StStart    = 7'b0100000,
    StWait     = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StTally;
        end
      end
      StTally: begin
        cmd_o.tally = 1'b1;
        state_d     = sts_i.pulse_event ? StProduct : StStart;
      end
      StProduct: begin
        cmd_o.product = 1'b1;
        state_d       = StSubtract;
      end
      StSubtract: begin
        cmd_o.subtract = 1'b1;
        state_d        = StRing;
      end
      StRing: begin
        cmd_o.ring = 1'b1;
        state_d    = StStart;
      end
      StStart: begin
        cmd_o.div_start = 1'b1;
        state_d         = StWait;
      end
      StWait: begin
        if (!sts_i.div_busy && out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/encoder_period_speed_meter_unit.sv @@
// encoder period speed meter top level: config registers, controller and datapath
// steps: capture, tally, with a pulse also product, subtract and ring, then divider start and wait
// the result loads when both dividers finish and the output is free; W = 24 + clog2(RING_DEPTH) is the divider width
// the pace is set by the two parallel bit-serial dividers; a new transaction is taken while a result waits
// reset: asynchronous active low; config to defaults, period 9999, ring, tallies cleared
// ring entries are cleared through per-entry valid bits, so no clearing pass is needed
module encoder_period_speed_meter_unit
  import epsm_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  action_i,
  input  logic                  overflow_flag_i,
  input  logic                  pulse_flag_i,
  input  logic [SpanWidth-1:0]  latched_count_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ValWidth-1:0]   period_ticks_o,
  output logic [ValWidth-1:0]   speed_rpm_o,
  output logic [ValWidth-1:0]   average_speed_rpm_o,
  output logic                  average_invalid_o,
  output logic [TotalWidth-1:0] pulse_total_o
);

  cfg_t       cfg_q;
  cmd_t       cmd;
  sts_t       sts;
  logic [1:0] reg_index;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.counter_span    <= SpanReset;
      cfg_q.stale_limit     <= LimitReset;
      cfg_q.speed_numerator <= NumReset;
    end else if (cfg_write) begin
      unique case (reg_index)
        RegCounterSpan:    cfg_q.counter_span    <= pwdata[SpanWidth-1:0];
        RegStaleLimit:     cfg_q.stale_limit     <= pwdata[LimitWidth-1:0];
        RegSpeedNumerator: cfg_q.speed_numerator <= pwdata[NumWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      RegCounterSpan:    prdata = 32'(cfg_q.counter_span);
      RegStaleLimit:     prdata = 32'(cfg_q.stale_limit);
      RegSpeedNumerator: prdata = 32'(cfg_q.speed_numerator);
      default:           prdata = '0;
    endcase
  end

  epsm_controller u_controller (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  epsm_datapath #(
    .RING_DEPTH(RING_DEPTH)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .action_i            (action_i),
    .overflow_flag_i     (overflow_flag_i),
    .pulse_flag_i        (pulse_flag_i),
    .latched_count_i     (latched_count_i),
    .period_ticks_o      (period_ticks_o),
    .speed_rpm_o         (speed_rpm_o),
    .average_speed_rpm_o (average_speed_rpm_o),
    .average_invalid_o   (average_invalid_o),
    .pulse_total_o       (pulse_total_o)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.capture, cmd.tally, cmd.product, cmd.subtract, cmd.ring,
              cmd.div_start, cmd.load_out}))
    else $error("more than one datapath command at once");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !sts.div_busy)
    else $error("result loaded while a division runs");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> in_stall_o)
    else $error("input not stalled after a transaction was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_o)
    else $error("loaded result not presented");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> sts.div_busy)
    else $error("divider did not start");
`endif

endmodule

@@ tb/sv/tb_encoder_period_speed_meter_unit.sv @@
// self-checking testbench for the encoder period speed meter unit
`timescale 1ns / 1ps

module tb_encoder_period_speed_meter_unit;
  import epsm_pkg::*;

  localparam int unsigned Depth     = 8;
  localparam int unsigned DrainWait = 40;
  localparam logic        ActEvent  = 1'b0;
  localparam logic        ActRead   = 1'b1;

  typedef struct packed {
    logic [ValWidth-1:0]   period;
    logic [ValWidth-1:0]   speed;
    logic [ValWidth-1:0]   avg;
    logic                  invalid;
    logic [TotalWidth-1:0] total;
  } meter_reading_t;

  typedef enum logic {RowItem, RowConfig} row_kind_e;

  typedef struct {
    row_kind_e      kind;
    logic           act;
    logic           ovf;
    logic           pls;
    logic [15:0]    lat;
    bit             typed;
    meter_reading_t want;
    logic [1:0]     reg_idx;
    logic [31:0]    reg_val;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [3:0]            paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  action_i;
  logic                  overflow_flag_i;
  logic                  pulse_flag_i;
  logic [SpanWidth-1:0]  latched_count_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [ValWidth-1:0]   period_ticks_o;
  logic [ValWidth-1:0]   speed_rpm_o;
  logic [ValWidth-1:0]   average_speed_rpm_o;
  logic                  average_invalid_o;
  logic [TotalWidth-1:0] pulse_total_o;

  encoder_period_speed_meter_unit #(.RING_DEPTH(Depth)) u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .action_i, .overflow_flag_i, .pulse_flag_i,
    .latched_count_i, .out_valid_o, .out_stall_i, .period_ticks_o, .speed_rpm_o,
    .average_speed_rpm_o, .average_invalid_o, .pulse_total_o
  );

  // configuration copy
  logic [SpanWidth-1:0]  span_cfg;
  logic [LimitWidth-1:0] limit_cfg;
  logic [NumWidth-1:0]   numerator_cfg;

  // predicted meter state
  longint unsigned last_period;
  int unsigned     overflow_count;
  longint unsigned period_hist [Depth];
  int unsigned     hist_slot;
  longint unsigned hist_sum;
  int unsigned     pulse_count;

  meter_reading_t pending_readings [$];
  stim_row_t      directed_rows [$];

  bit quiet;
  int errors;
  int items_sent;
  int readings_checked;
  int stale_clears;
  int reg_writes;
  int stall_hold;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    #100_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_failure(string msg);
    errors++;
    if (errors <= 40) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void reset_meter_model();
    span_cfg       = SpanReset;
    limit_cfg      = LimitReset;
    numerator_cfg  = NumReset;
    last_period    = PeriodReset;
    overflow_count = 0;
    foreach (period_hist[i]) period_hist[i] = 0;
    hist_slot      = 0;
    hist_sum       = 0;
    pulse_count    = 0;
  endfunction

  function automatic meter_reading_t compute_reading(logic act, logic ovf, logic pls,
                                                     logic [15:0] lat);
    meter_reading_t  r;
    longint unsigned span_total;
    longint unsigned p;
    longint unsigned spd;
    longint unsigned av;
    if (act == ActRead) begin
      r.total     = pulse_count[15:0];
      pulse_count = 0;
    end else begin
      last_period = (longint'(PresetFactor) * span_cfg) & Full24;
      if (ovf) overflow_count++;
      if (overflow_count > limit_cfg) begin
        overflow_count = 0;
        foreach (period_hist[i]) period_hist[i] = 0;
        hist_sum = 0;
        stale_clears++;
      end
      if (pls) begin
        span_total = longint'(span_cfg) * (overflow_count + 1);
        p = (span_total > lat) ? span_total - lat : 0;
        if (p > Full24) p = Full24;
        last_period = p;
        if (pulse_count < PulseTallyMax) pulse_count++;
        overflow_count = 0;
        hist_sum = hist_sum - period_hist[hist_slot] + last_period;
        period_hist[hist_slot] = last_period;
        hist_slot = (hist_slot + 1) % Depth;
      end
      r.total = pulse_count[15:0];
    end
    spd = (last_period == 0) ? Full24 : numerator_cfg / last_period;
    if (spd > Full24) spd = Full24;
    if (hist_sum == 0) begin
      av        = Full24;
      r.invalid = 1'b1;
    end else begin
      av        = (longint'(numerator_cfg) * Depth) / hist_sum;
      if (av > Full24) av = Full24;
      r.invalid = 1'b0;
    end
    r.period = last_period[23:0];
    r.speed  = spd[23:0];
    r.avg    = av[23:0];
    return r;
  endfunction

  // called at a rising edge; returns at the edge after the gap
  task automatic send_transaction(logic act, logic ovf, logic pls, logic [15:0] lat,
                                  bit typed = 0, meter_reading_t want = '0);
    meter_reading_t predicted;
    int gap;
    in_valid_i      <= 1'b1;
    action_i        <= act;
    overflow_flag_i <= ovf;
    pulse_flag_i    <= pls;
    latched_count_i <= lat;
    do @(posedge clk_i); while (in_stall_o);
    predicted = compute_reading(act, ovf, pls, lat);
    pending_readings.push_back(typed ? want : predicted);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_until_idle();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] val);
    logic [31:0] masked;
    case (idx)
      RegCounterSpan: begin
        masked   = val & 32'h0000_FFFF;
        span_cfg = masked[SpanWidth-1:0];
      end
      RegStaleLimit: begin
        masked    = val & 32'h0000_007F;
        limit_cfg = masked[LimitWidth-1:0];
      end
      default: begin
        masked        = val & 32'h00FF_FFFF;
        numerator_cfg = masked[NumWidth-1:0];
      end
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== masked)
      report_failure($sformatf("register %0d reads %0h, wrote %0h", idx, prdata, masked));
    psel    <= 1'b0;
    penable <= 1'b0;
    reg_writes++;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_latched();
    if ($urandom_range(0, 99) < 85) return 16'($urandom_range(0, span_cfg));
    return 16'($urandom);
  endfunction

  task automatic run_random_phase(logic [15:0] span, logic [6:0] limit, logic [23:0] num,
                                  int target);
    int sent_before;
    int k;
    int r;
    wait_until_idle();
    write_register(RegCounterSpan, {16'($urandom), span});
    write_register(RegStaleLimit, {25'($urandom), limit});
    write_register(RegSpeedNumerator, {8'($urandom), num});
    sent_before = items_sent;
    while (items_sent - sent_before < target) begin
      if ((items_sent % 50) == 0) quiet = ($urandom_range(0, 3) == 0);
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, limit_cfg + 2) : $urandom_range(0, 3);
      repeat (k) send_transaction(ActEvent, 1'b1, 1'b0, 16'($urandom));
      send_transaction(ActEvent, 1'($urandom), 1'b1, pick_latched());
      r = $urandom_range(0, 99);
      if (r < 15)
        send_transaction(ActRead, 1'($urandom), 1'($urandom), 16'($urandom));
      else if (r < 25)
        send_transaction(ActEvent, 1'($urandom), 1'($urandom), 16'($urandom));
    end
    quiet = 0;
  endtask

  function automatic void add_item(logic act, logic ovf, logic pls, logic [15:0] lat);
    stim_row_t row;
    row = '{kind: RowItem, act: act, ovf: ovf, pls: pls, lat: lat, typed: 0,
            want: '0, reg_idx: '0, reg_val: '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_typed(logic act, logic ovf, logic pls, logic [15:0] lat,
                                    meter_reading_t want);
    stim_row_t row;
    row = '{kind: RowItem, act: act, ovf: ovf, pls: pls, lat: lat, typed: 1,
            want: want, reg_idx: '0, reg_val: '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_config(logic [1:0] idx, logic [31:0] val);
    stim_row_t row;
    row = '{kind: RowConfig, act: 0, ovf: 0, pls: 0, lat: '0, typed: 0,
            want: '0, reg_idx: idx, reg_val: val};
    directed_rows.push_back(row);
  endfunction

  task automatic check_field(string name, longint unsigned got, longint unsigned want);
    if (got != want) report_failure($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  always @(posedge clk_i) begin
    meter_reading_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_readings.size() == 0) begin
        report_failure($sformatf("unexpected reading, period %0d", period_ticks_o));
      end else begin
        want = pending_readings.pop_front();
        readings_checked++;
        check_field("period_ticks", period_ticks_o, want.period);
        check_field("speed_rpm", speed_rpm_o, want.speed);
        check_field("average_speed_rpm", average_speed_rpm_o, want.avg);
        check_field("average_invalid", average_invalid_o, want.invalid);
        check_field("pulse_total", pulse_total_o, want.total);
      end
    end
  end

  // output stall: alternating runs of stall and no stall, held low while quiet
  always @(posedge clk_i) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      stall_hold  <= pick_gap();
      out_stall_i <= quiet ? 1'b0 : ~out_stall_i;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid_i      = 1'b0;
    action_i        = 1'b0;
    overflow_flag_i = 1'b0;
    pulse_flag_i    = 1'b0;
    latched_count_i = '0;
    out_stall_i     = 1'b0;
    stall_hold      = 0;
    quiet           = 0;
    errors          = 0;
    reset_meter_model();

    // reset defaults, ring empty
    add_typed(ActRead, 1'b1, 1'b1, 16'hFFFF, '{24'd9999, 24'd93, Full24, 1'b1, 16'd0});
    add_typed(ActEvent, 1'b0, 1'b0, 16'h0000, '{24'd6553500, 24'd0, Full24, 1'b1, 16'd0});
    add_item(ActEvent, 1'b0, 1'b1, 16'h0000);
    add_item(ActEvent, 1'b0, 1'b1, 16'hFFFF);
    add_item(ActEvent, 1'b1, 1'b1, 16'h8000);
    add_item(ActEvent, 1'b1, 1'b0, 16'h5555);
    add_item(ActRead, 1'b0, 1'b0, 16'hAAAA);
    // latched count beyond the span clamps the period
    add_config(RegCounterSpan, 32'd1);
    add_item(ActEvent, 1'b0, 1'b1, 16'hFFFF);
    add_item(ActEvent, 1'b0, 1'b1, 16'h0000);
    // average saturation
    add_config(RegSpeedNumerator, 32'h00FF_FFFF);
    add_item(ActEvent, 1'b0, 1'b1, 16'h0000);
    // stale overflows clear the ring
    add_config(RegStaleLimit, 32'd1);
    add_item(ActEvent, 1'b1, 1'b0, 16'h0000);
    add_typed(ActEvent, 1'b1, 1'b0, 16'h0000, '{24'd100, 24'd167772, Full24, 1'b1, 16'd3});
    add_item(ActEvent, 1'b1, 1'b1, 16'h0000);
    // ring wrap
    repeat (9) add_item(ActEvent, 1'b0, 1'b1, 16'h0000);
    add_config(RegCounterSpan, 32'd65535);
    add_config(RegStaleLimit, 32'd127);
    add_config(RegSpeedNumerator, 32'd1);
    add_item(ActEvent, 1'b0, 1'b1, 16'h0001);
    add_item(ActRead, 1'b1, 1'b1, 16'h0000);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == RowConfig) begin
        wait_until_idle();
        write_register(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_transaction(directed_rows[i].act, directed_rows[i].ovf, directed_rows[i].pls,
                         directed_rows[i].lat, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    run_random_phase(16'd65535, 7'd127, 24'hFF_FFFF, 180);
    run_random_phase(16'd1, 7'd1, 24'd1, 180);
    run_random_phase(16'($urandom_range(16, 4000)), 7'($urandom_range(1, 8)),
                     24'($urandom_range(1, 24'hFF_FFFF)), 180);
    run_random_phase(16'($urandom_range(1, 65535)), 7'($urandom_range(1, 127)),
                     24'($urandom_range(1, 24'hFF_FFFF)), 180);
    run_random_phase(16'd65535, 7'd100, 24'd937500, 180);

    wait_until_idle();
    $display("run covered %0d transactions in, %0d readings checked, %0d register writes",
             items_sent, readings_checked, reg_writes);
    $display("stale ring clears seen: %0d, mismatches: %0d", stale_clears, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
